[rtl/gep_ag_pkg.sv]
// ----------------------------------------------------------------------------
// gep_ag_pkg
// Shared types, codes and constants of the address generator.
// ----------------------------------------------------------------------------
package gep_ag_pkg;

  // address arithmetic width, at most the full field width
  localparam int unsigned ADDR_BITS = 64;
  localparam int unsigned FULL_W    = 64;
  localparam int unsigned IDX_W_W   = 7;
  localparam int unsigned SEL_W     = $clog2(FULL_W);
  localparam int unsigned VS_W      = 2;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned CFG_IDX_W = 2;

  // multiplier split into two halves of at most 32 bits
  localparam int unsigned LO_W   = (ADDR_BITS + 1) / 2;
  localparam int unsigned HI_W   = ADDR_BITS - LO_W;
  localparam int unsigned PROD_W = 2 * ADDR_BITS;

  localparam logic [FULL_W-1:0] ADDR_MASK = {FULL_W{1'b1}} >> (FULL_W - ADDR_BITS);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NO_UNSIGNED_WRAP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NO_SIGNED_WRAP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IN_BOUNDS        = 2'd2;

  // operand value states, poison covers the unused code too
  localparam logic [VS_W-1:0] VS_UNDEF  = 2'd1;
  localparam logic [VS_W-1:0] VS_POISON = 2'd2;

  typedef enum logic {
    CMD_BEGIN = 1'b0,
    CMD_TERM  = 1'b1
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_VALID  = 2'd0,
    ST_POISON = 2'd1,
    ST_UNDEF  = 2'd2
  } status_e;

  typedef struct packed {
    logic no_unsigned_wrap;
    logic no_signed_wrap;
    logic in_bounds;
  } cfg_t;

  // fields that travel unchanged alongside the index arithmetic
  typedef struct packed {
    cmd_e              cmd;
    logic [FULL_W-1:0] base_address;
    logic [FULL_W-1:0] base_object_offset;
    logic [FULL_W-1:0] object_size;
    logic [VS_W-1:0]   value_state;
    logic              last;
  } item_t;

  // scaled term handed to the accumulator
  typedef struct packed {
    item_t                item;
    logic [ADDR_BITS-1:0] offset;
    logic                 fail;
  } term_t;

endpackage

[rtl/gep_ag_index_scaler.sv]
// ----------------------------------------------------------------------------
// gep_ag_index_scaler
// Canonicalises the index and multiplies it by the scale, with wrap checks.
// ----------------------------------------------------------------------------
module gep_ag_index_scaler (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  gep_ag_pkg::cfg_t                     cfg_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  gep_ag_pkg::item_t                    item_i,
  input  logic [gep_ag_pkg::FULL_W-1:0]        index_value_i,
  input  logic [gep_ag_pkg::IDX_W_W-1:0]       index_width_i,
  input  logic [gep_ag_pkg::FULL_W-1:0]        scale_factor_i,
  output logic                                 term_valid_o,
  output gep_ag_pkg::term_t                    term_o,
  input  logic                                 term_take_i
);

  localparam int unsigned A  = gep_ag_pkg::ADDR_BITS;
  localparam int unsigned FW = gep_ag_pkg::FULL_W;
  localparam int unsigned IW = gep_ag_pkg::IDX_W_W;
  localparam int unsigned LW = gep_ag_pkg::LO_W;
  localparam int unsigned HW = gep_ag_pkg::HI_W;
  localparam int unsigned PW = gep_ag_pkg::PROD_W;

  // stage enables, a stage moves when empty or when the next one moves
  logic en1, en2, en3, en4, en5;

  // stage 1: raw request
  logic                  s1_valid_q;
  gep_ag_pkg::item_t     s1_item_q;
  logic [FW-1:0]         s1_index_q;
  logic [IW-1:0]         s1_width_q;
  logic [FW-1:0]         s1_scale_q;

  // stage 2: canonical operands
  logic                  s2_valid_q;
  gep_ag_pkg::item_t     s2_item_q;
  logic [A-1:0]          s2_idx_q, s2_idx_d;
  logic [A-1:0]          s2_scl_q;
  logic                  s2_fail_q, s2_fail_d;

  // stage 3: partial products
  logic                  s3_valid_q;
  gep_ag_pkg::item_t     s3_item_q;
  logic [A-1:0]          s3_idx_q, s3_scl_q;
  logic                  s3_fail_q;
  logic [2*LW-1:0]       p00_q, p00_d;
  logic [LW+HW-1:0]      p01_q, p01_d, p10_q, p10_d;
  logic [2*HW-1:0]       p11_q, p11_d;

  // stage 4: full product
  logic                  s4_valid_q;
  gep_ag_pkg::item_t     s4_item_q;
  logic [A-1:0]          s4_idx_q, s4_scl_q;
  logic                  s4_fail_q;
  logic [PW-1:0]         prod_q, prod_d;

  // stage 5: scaled term
  logic                  s5_valid_q;
  gep_ag_pkg::term_t     term_q, term_d;

  assign en5 = !s5_valid_q || term_take_i;
  assign en4 = !s4_valid_q || en5;
  assign en3 = !s3_valid_q || en4;
  assign en2 = !s2_valid_q || en3;
  assign en1 = !s1_valid_q || en2;
  assign in_stall_o = !en1;

  // index canonicalising
  logic [IW-1:0] w_eff, w_m1;
  logic [FW-1:0] w_mask, v_masked, v_sext, top_bits, top_part;
  logic          sgn, nsw_bad, nuw_bad;

  always_comb begin
    if (s1_width_q == '0) begin
      w_eff = IW'(1);
    end else if (s1_width_q > IW'(FW)) begin
      w_eff = IW'(FW);
    end else begin
      w_eff = s1_width_q;
    end
    w_m1     = w_eff - IW'(1);
    w_mask   = {FW{1'b1}} >> (IW'(FW) - w_eff);
    v_masked = s1_index_q & w_mask;
    sgn      = v_masked[w_m1[gep_ag_pkg::SEL_W-1:0]];
    v_sext   = sgn ? (v_masked | ~w_mask) : v_masked;
    top_bits = ~(gep_ag_pkg::ADDR_MASK >> 1);
    top_part = v_sext & top_bits;
    nsw_bad  = (top_part != '0) && (top_part != top_bits);
    nuw_bad  = (v_masked & ~gep_ag_pkg::ADDR_MASK) != '0;
    s2_idx_d  = v_sext[A-1:0];
    s2_fail_d = (w_eff > IW'(A)) &&
                ((cfg_i.no_signed_wrap && nsw_bad) || (cfg_i.no_unsigned_wrap && nuw_bad));
  end

  // partial products, each at most half by half
  always_comb begin
    p00_d = (2*LW)'(s2_idx_q[LW-1:0]) * (2*LW)'(s2_scl_q[LW-1:0]);
    p01_d = (LW+HW)'(s2_idx_q[LW-1:0]) * (LW+HW)'(s2_scl_q[A-1:LW]);
    p10_d = (LW+HW)'(s2_idx_q[A-1:LW]) * (LW+HW)'(s2_scl_q[LW-1:0]);
    p11_d = (2*HW)'(s2_idx_q[A-1:LW]) * (2*HW)'(s2_scl_q[A-1:LW]);
  end

  assign prod_d = PW'(p00_q) + (PW'(p01_q) << LW) + (PW'(p10_q) << LW) + (PW'(p11_q) << (2*LW));

  // overflow checks: signed high half from the unsigned product
  logic [A-1:0] prod_hi, prod_hi_s;
  logic         mul_nuw_bad, mul_nsw_bad;

  always_comb begin
    prod_hi     = prod_q[PW-1:A];
    prod_hi_s   = prod_hi - (s4_idx_q[A-1] ? s4_scl_q : '0) - (s4_scl_q[A-1] ? s4_idx_q : '0);
    mul_nuw_bad = prod_hi != '0;
    mul_nsw_bad = prod_hi_s != {A{prod_q[A-1]}};
    term_d.item   = s4_item_q;
    term_d.offset = prod_q[A-1:0];
    term_d.fail   = s4_fail_q || (cfg_i.no_unsigned_wrap && mul_nuw_bad) ||
                    (cfg_i.no_signed_wrap && mul_nsw_bad);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
      s5_valid_q <= 1'b0;
    end else begin
      if (en1) s1_valid_q <= in_valid_i;
      if (en2) s2_valid_q <= s1_valid_q;
      if (en3) s3_valid_q <= s2_valid_q;
      if (en4) s4_valid_q <= s3_valid_q;
      if (en5) s5_valid_q <= s4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_item_q  <= item_i;
      s1_index_q <= index_value_i;
      s1_width_q <= index_width_i;
      s1_scale_q <= scale_factor_i;
    end
    if (en2) begin
      s2_item_q <= s1_item_q;
      s2_idx_q  <= s2_idx_d;
      s2_scl_q  <= s1_scale_q[A-1:0];
      s2_fail_q <= s2_fail_d;
    end
    if (en3) begin
      s3_item_q <= s2_item_q;
      s3_idx_q  <= s2_idx_q;
      s3_scl_q  <= s2_scl_q;
      s3_fail_q <= s2_fail_q;
      p00_q     <= p00_d;
      p01_q     <= p01_d;
      p10_q     <= p10_d;
      p11_q     <= p11_d;
    end
    if (en4) begin
      s4_item_q <= s3_item_q;
      s4_idx_q  <= s3_idx_q;
      s4_scl_q  <= s3_scl_q;
      s4_fail_q <= s3_fail_q;
      prod_q    <= prod_d;
    end
    if (en5) begin
      term_q <= term_d;
    end
  end

  assign term_valid_o = s5_valid_q;
  assign term_o       = term_q;

endmodule

[rtl/gep_ag_accumulator.sv]
// ----------------------------------------------------------------------------
// gep_ag_accumulator
// Applies scaled terms to the pointer state and registers the result.
// ----------------------------------------------------------------------------
module gep_ag_accumulator (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  gep_ag_pkg::cfg_t                       cfg_i,
  input  logic                                   term_valid_i,
  input  gep_ag_pkg::term_t                      term_i,
  output logic                                   term_take_o,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic [gep_ag_pkg::STATUS_W-1:0]        status_o,
  output logic [gep_ag_pkg::FULL_W-1:0]          result_address_o,
  output logic signed [gep_ag_pkg::FULL_W-1:0]   result_object_offset_o
);

  localparam int unsigned A  = gep_ag_pkg::ADDR_BITS;
  localparam int unsigned FW = gep_ag_pkg::FULL_W;

  logic [FW-1:0] cur_addr_q, cur_addr_d;
  logic [A-1:0]  cur_obj_q, cur_obj_d;
  logic [FW-1:0] obj_size_q, obj_size_d;
  logic [A-1:0]  off_sum_q, off_sum_d;
  logic          poison_q, poison_d;
  logic          undef_q, undef_d;
  logic          wrap_failed_q, wrap_failed_d;

  logic                  out_valid_q;
  gep_ag_pkg::status_e   status_q, status_d;
  logic [FW-1:0]         res_addr_q, res_addr_d;
  logic [FW-1:0]         res_obj_q, res_obj_d;

  logic out_free, fire, fire_last;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign term_take_o = !term_i.item.last || out_free;
  assign fire        = term_valid_i && term_take_o;
  assign fire_last   = fire && term_i.item.last;

  logic [A-1:0] off, new_addr, new_obj, new_sum;
  logic         c_addr, c_sum, is_poison, is_undef, apply_bad, nz;
  logic [FW-1:0] obj_ext;

  always_comb begin
    off       = term_i.offset;
    nz        = off != '0;
    {c_addr, new_addr} = (A+1)'(cur_addr_q[A-1:0]) + (A+1)'(off);
    new_obj   = cur_obj_q + off;
    {c_sum, new_sum}   = (A+1)'(off_sum_q) + (A+1)'(off);
    apply_bad = nz && (
                  (cfg_i.no_unsigned_wrap && (c_addr || c_sum)) ||
                  (cfg_i.no_signed_wrap && (off[A-1] ? !c_addr : c_addr)) ||
                  (cfg_i.no_signed_wrap && (off_sum_q[A-1] == off[A-1]) &&
                   (new_sum[A-1] != off_sum_q[A-1])) ||
                  (cfg_i.in_bounds && (new_obj[A-1] || (FW'(new_obj) > obj_size_q))));
    is_poison = term_i.item.value_state >= gep_ag_pkg::VS_POISON;
    is_undef  = term_i.item.value_state == gep_ag_pkg::VS_UNDEF;

    cur_addr_d    = cur_addr_q;
    cur_obj_d     = cur_obj_q;
    obj_size_d    = obj_size_q;
    off_sum_d     = off_sum_q;
    poison_d      = poison_q;
    undef_d       = undef_q;
    wrap_failed_d = wrap_failed_q;

    unique case (term_i.item.cmd)
      gep_ag_pkg::CMD_BEGIN: begin
        cur_addr_d    = term_i.item.base_address;
        cur_obj_d     = term_i.item.base_object_offset[A-1:0];
        obj_size_d    = term_i.item.object_size;
        off_sum_d     = '0;
        wrap_failed_d = 1'b0;
        poison_d      = is_poison;
        undef_d       = is_undef;
      end
      gep_ag_pkg::CMD_TERM: begin
        poison_d = poison_q || is_poison;
        undef_d  = undef_q || is_undef;
        if (!wrap_failed_q) begin
          if (term_i.fail || apply_bad) begin
            wrap_failed_d = 1'b1;
          end else if (nz) begin
            cur_addr_d = (cur_addr_q & ~gep_ag_pkg::ADDR_MASK) | FW'(new_addr);
            cur_obj_d  = new_obj;
            off_sum_d  = new_sum;
          end
        end
      end
      default: ;
    endcase

    obj_ext = FW'(cur_obj_d);
    if (cur_obj_d[A-1]) obj_ext = obj_ext | ~gep_ag_pkg::ADDR_MASK;

    if (poison_d || (!undef_d && wrap_failed_d)) begin
      status_d   = gep_ag_pkg::ST_POISON;
      res_addr_d = '0;
      res_obj_d  = '0;
    end else if (undef_d) begin
      status_d   = gep_ag_pkg::ST_UNDEF;
      res_addr_d = '0;
      res_obj_d  = '0;
    end else begin
      status_d   = gep_ag_pkg::ST_VALID;
      res_addr_d = cur_addr_d;
      res_obj_d  = obj_ext;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_addr_q    <= '0;
      cur_obj_q     <= '0;
      obj_size_q    <= '0;
      off_sum_q     <= '0;
      poison_q      <= 1'b0;
      undef_q       <= 1'b0;
      wrap_failed_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (fire_last) begin
        cur_addr_q    <= '0;
        cur_obj_q     <= '0;
        obj_size_q    <= '0;
        off_sum_q     <= '0;
        poison_q      <= 1'b0;
        undef_q       <= 1'b0;
        wrap_failed_q <= 1'b0;
      end else if (fire) begin
        cur_addr_q    <= cur_addr_d;
        cur_obj_q     <= cur_obj_d;
        obj_size_q    <= obj_size_d;
        off_sum_q     <= off_sum_d;
        poison_q      <= poison_d;
        undef_q       <= undef_d;
        wrap_failed_q <= wrap_failed_d;
      end
      if (fire_last) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_last) begin
      status_q   <= status_d;
      res_addr_q <= res_addr_d;
      res_obj_q  <= res_obj_d;
    end
  end

  assign out_valid_o            = out_valid_q;
  assign status_o               = status_q;
  assign result_address_o       = res_addr_q;
  assign result_object_offset_o = res_obj_q;

  a_result_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(fire_last))
    else $error("result raised without a last request");

  a_state_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_last |=> (!wrap_failed_q && !poison_q && !undef_q && off_sum_q == '0))
    else $error("state not cleared after last request");

  a_failed_term_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && !term_i.item.last && term_i.item.cmd == gep_ag_pkg::CMD_TERM && wrap_failed_q)
    |=> ($stable(cur_addr_q) && $stable(cur_obj_q) && $stable(off_sum_q)))
    else $error("term changed state after a failed check");

  a_bad_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q != gep_ag_pkg::ST_VALID) |-> (res_addr_q == '0 && res_obj_q == '0))
    else $error("poison or undef result carries a pointer");

endmodule

[rtl/gep_address_generator_unit.sv]
// ----------------------------------------------------------------------------
// gep_address_generator_unit
// Pointer address generator: base plus a sum of scaled, checked indices.
// ----------------------------------------------------------------------------
// throughput: one request per cycle, set by the accumulator's update of the
//   pointer state, except while a last request waits on a stalled result;
//   the multiply spans the partial-product and full-product stages
// reset: clears pipeline valids, pointer state and configuration at once
//   (no clearing pass), so the block accepts requests right after reset
// ----------------------------------------------------------------------------
module gep_address_generator_unit (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // configuration write port
  input  logic                                   cfg_we_i,
  input  logic [gep_ag_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic                                   cfg_data_i,
  // request channel
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic                                   cmd_i,
  input  logic [gep_ag_pkg::FULL_W-1:0]          base_address_i,
  input  logic signed [gep_ag_pkg::FULL_W-1:0]   base_object_offset_i,
  input  logic [gep_ag_pkg::FULL_W-1:0]          object_size_i,
  input  logic [gep_ag_pkg::FULL_W-1:0]          index_value_i,
  input  logic [gep_ag_pkg::IDX_W_W-1:0]         index_width_i,
  input  logic [gep_ag_pkg::FULL_W-1:0]          scale_factor_i,
  input  logic [gep_ag_pkg::VS_W-1:0]            value_state_i,
  input  logic                                   last_i,
  // result channel
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic [gep_ag_pkg::STATUS_W-1:0]        status_o,
  output logic [gep_ag_pkg::FULL_W-1:0]          result_address_o,
  output logic signed [gep_ag_pkg::FULL_W-1:0]   result_object_offset_o
);

  // configuration registers, to be written only while the block is idle; the block does not enforce this
  gep_ag_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      // an index beyond the register list is ignored
      unique case (cfg_idx_i)
        gep_ag_pkg::CFG_NO_UNSIGNED_WRAP: cfg_q.no_unsigned_wrap <= cfg_data_i;
        gep_ag_pkg::CFG_NO_SIGNED_WRAP:   cfg_q.no_signed_wrap   <= cfg_data_i;
        gep_ag_pkg::CFG_IN_BOUNDS:        cfg_q.in_bounds        <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // fields that ride along with the index arithmetic
  gep_ag_pkg::item_t item;

  always_comb begin
    item.cmd                = gep_ag_pkg::cmd_e'(cmd_i);
    item.base_address       = base_address_i;
    item.base_object_offset = base_object_offset_i;
    item.object_size        = object_size_i;
    item.value_state        = value_state_i;
    item.last               = last_i;
  end

  // scaled term between the two halves
  logic              term_valid;
  logic              term_take;
  gep_ag_pkg::term_t term;

  // canonicalise the index, multiply by the scale and check the product;
  // begin requests flow through the same stages so order is kept
  gep_ag_index_scaler u_scaler (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .item_i         (item),
    .index_value_i  (index_value_i),
    .index_width_i  (index_width_i),
    .scale_factor_i (scale_factor_i),
    .term_valid_o   (term_valid),
    .term_o         (term),
    .term_take_i    (term_take)
  );

  // apply the term to address, object offset and running sum; only a last
  // request needs room in the result register, others never wait
  gep_ag_accumulator u_accumulator (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cfg_i                  (cfg_q),
    .term_valid_i           (term_valid),
    .term_i                 (term),
    .term_take_o            (term_take),
    .out_valid_o            (out_valid_o),
    .out_stall_i            (out_stall_i),
    .status_o               (status_o),
    .result_address_o       (result_address_o),
    .result_object_offset_o (result_object_offset_o)
  );

endmodule
